### rtl/tdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_pkg
// Shared widths, types and register codes of the torus distance/gradient unit.
// ----------------------------------------------------------------------------
package tdg_pkg;

	localparam int PT_W          = 32;
	localparam int RAD_W         = 31;
	localparam int D_W           = 33;
	localparam int MAG_W         = 32;
	localparam int RHO_W         = 33;
	localparam int E_W           = 34;
	localparam int AE_W          = 33;
	localparam int S_W           = 34;
	localparam int DEN_W         = 67;
	localparam int GRAD_W        = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int GRAD_FRAC_DEF = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X     = 3'd0,
		REG_CENTER_Y     = 3'd1,
		REG_CENTER_Z     = 3'd2,
		REG_MAJOR_RADIUS = 3'd3,
		REG_MINOR_RADIUS = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic xneg;
		logic xnz;
		logic yneg;
		logic ynz;
		logic zpos;
	} sgn_t;

	typedef struct packed {
		logic [MAG_W-1:0] ax;
		logic [MAG_W-1:0] ay;
		logic [MAG_W-1:0] az;
		sgn_t             sgn;
	} side1_t;

	typedef struct packed {
		logic [RHO_W-1:0] rho;
		logic [AE_W-1:0]  ae;
		logic             eneg;
		logic             enz;
		logic             deg;
		side1_t           s1;
	} side2_t;

	typedef struct packed {
		logic            gneg;
		logic            deg;
		logic [PT_W-1:0] dist_val;
	} xside_t;

endpackage

### rtl/torus_distance_gradient_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_distance_gradient_top
// Signed distance and unit gradient of a point to a torus around the z axis.
// ----------------------------------------------------------------------------
// Usage:
//   Load center_x/y/z, major_radius and minor_radius through the cfg channel
//   (cfg_valid/cfg_ready, cfg_index, cfg_data); cfg_ready is always high.
//   Present a point on point_x/y/z with start; busy stays low, so a point is
//   taken on every cycle start is high. One result comes back per point, in
//   order, on distance/grad_x/grad_y/grad_z/degenerate, marked by done for a
//   single cycle.
//   The pipeline holds 33 and 34 stages for the two square roots, one
//   stage per quotient bit in the gradient dividers, plus the multiply,
//   add and output registers. Throughput is one point per cycle.
//   Reset clears all valid bits and the config registers to zero; no results are
//   in flight afterwards. The receiver has no way to stall: results flow
//   out at the rate points went in.
// ----------------------------------------------------------------------------
module torus_distance_gradient_top
	import tdg_pkg::*;
#(
	parameter int GRAD_FRAC_BITS = GRAD_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [PT_W-1:0]   point_x,
	input  logic signed [PT_W-1:0]   point_y,
	input  logic signed [PT_W-1:0]   point_z,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [PT_W-1:0]          cfg_data,
	output logic                     done,
	output logic signed [PT_W-1:0]   distance,
	output logic signed [GRAD_W-1:0] grad_x,
	output logic signed [GRAD_W-1:0] grad_y,
	output logic signed [GRAD_W-1:0] grad_z,
	output logic                     degenerate
);

	localparam int G = GRAD_FRAC_BITS;

	logic [PT_W-1:0]  center_x_q;
	logic [PT_W-1:0]  center_y_q;
	logic [PT_W-1:0]  center_z_q;
	logic [RAD_W-1:0] major_q;
	logic [RAD_W-1:0] minor_q;

	logic             vld_s1;
	logic [D_W-1:0]   dx_s1;
	logic [D_W-1:0]   dy_s1;
	logic [D_W-1:0]   dz_s1;

	logic [D_W-1:0]   ax_w;
	logic [D_W-1:0]   ay_w;
	logic [D_W-1:0]   az_w;
	logic             vld_s2;
	logic [63:0]      ax2_s2;
	logic [63:0]      ay2_s2;
	side1_t           side1_s2;

	logic             vld_s3;
	logic [64:0]      sq_s3;
	side1_t           side1_s3;

	logic             rho_vld;
	logic [RHO_W-1:0] rho_w;
	logic [$bits(side1_t)-1:0] side1_vec;
	side1_t           side1_w;

	logic             vld_s4;
	logic [E_W-1:0]   e_s4;
	logic [RHO_W-1:0] rho_s4;
	side1_t           side1_s4;

	logic [E_W-1:0]   ae_w;
	logic             vld_s5;
	logic [65:0]      ae2_s5;
	logic [63:0]      az2_s5;
	logic [AE_W-1:0]  ae_s5;
	logic             eneg_s5;
	logic             enz_s5;
	logic [RHO_W-1:0] rho_s5;
	side1_t           side1_s5;

	logic             vld_s6;
	logic [66:0]      v_s6;
	side2_t           side2_s6;

	logic             s_vld;
	logic [S_W-1:0]   s_w;
	logic [$bits(side2_t)-1:0] side2_vec;
	side2_t           side2_w;
	logic [34:0]      dist_w;

	logic             vld_s7;
	logic [DEN_W-1:0] den_s7;
	logic [DEN_W-1:0] numx_s7;
	logic [DEN_W-1:0] numy_s7;
	logic [MAG_W-1:0] az_s7;
	logic [S_W-1:0]   s_s7;
	xside_t           xside_s7;
	logic             gyneg_s7;
	logic             gzneg_s7;

	logic             vld_x;
	logic             vld_y;
	logic             vld_z;
	logic [G:0]       qx;
	logic [G:0]       qy;
	logic [G:0]       qz;
	logic [$bits(xside_t)-1:0] xside_vec;
	xside_t           xside_w;
	logic             gyneg_w;
	logic             gzneg_w;

	function automatic logic [D_W-1:0] mag33(input logic [D_W-1:0] v);
		return v[D_W-1] ? D_W'(-v) : v;
	endfunction

	function automatic logic [GRAD_W-1:0] gmap(input logic [G:0] q, input logic neg,
		input logic deg);
		logic [31:0] m;
		m = 32'(q);
		m = neg ? 32'(-m) : m;
		return deg ? '0 : m[GRAD_W-1:0];
	endfunction

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			major_q    <= '0;
			minor_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CENTER_X:     center_x_q <= cfg_data;
				REG_CENTER_Y:     center_y_q <= cfg_data;
				REG_CENTER_Z:     center_z_q <= cfg_data;
				REG_MAJOR_RADIUS: major_q    <= cfg_data[RAD_W-1:0];
				REG_MINOR_RADIUS: minor_q    <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= rho_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= s_vld;
			done   <= vld_x;
		end
	end

	// offsets from the centre
	always_ff @(posedge clk) begin
		dx_s1 <= {point_x[PT_W-1], point_x} - {center_x_q[PT_W-1], center_x_q};
		dy_s1 <= {point_y[PT_W-1], point_y} - {center_y_q[PT_W-1], center_y_q};
		dz_s1 <= {point_z[PT_W-1], point_z} - {center_z_q[PT_W-1], center_z_q};
	end

	assign ax_w = mag33(dx_s1);
	assign ay_w = mag33(dy_s1);
	assign az_w = mag33(dz_s1);

	always_ff @(posedge clk) begin
		ax2_s2            <= ax_w[MAG_W-1:0] * ax_w[MAG_W-1:0];
		ay2_s2            <= ay_w[MAG_W-1:0] * ay_w[MAG_W-1:0];
		side1_s2.ax       <= ax_w[MAG_W-1:0];
		side1_s2.ay       <= ay_w[MAG_W-1:0];
		side1_s2.az       <= az_w[MAG_W-1:0];
		side1_s2.sgn.xneg <= dx_s1[D_W-1];
		side1_s2.sgn.xnz  <= |dx_s1;
		side1_s2.sgn.yneg <= dy_s1[D_W-1];
		side1_s2.sgn.ynz  <= |dy_s1;
		side1_s2.sgn.zpos <= !dz_s1[D_W-1] && (|dz_s1);
	end

	always_ff @(posedge clk) begin
		sq_s3    <= {1'b0, ax2_s2} + {1'b0, ay2_s2};
		side1_s3 <= side1_s2;
	end

	tdg_sqrt #(
		.RW (RHO_W),
		.SW ($bits(side1_t))
	) u_sqrt_rho (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_val   ({1'b0, sq_s3}),
		.in_side  (side1_s3),
		.out_vld  (rho_vld),
		.out_root (rho_w),
		.out_side (side1_vec)
	);

	assign side1_w = side1_t'(side1_vec);

	always_ff @(posedge clk) begin
		e_s4     <= {1'b0, rho_w} - {3'b0, major_q};
		rho_s4   <= rho_w;
		side1_s4 <= side1_w;
	end

	assign ae_w = e_s4[E_W-1] ? E_W'(-e_s4) : e_s4;

	always_ff @(posedge clk) begin
		ae2_s5   <= ae_w[AE_W-1:0] * ae_w[AE_W-1:0];
		az2_s5   <= side1_s4.az * side1_s4.az;
		ae_s5    <= ae_w[AE_W-1:0];
		eneg_s5  <= e_s4[E_W-1];
		enz_s5   <= |e_s4;
		rho_s5   <= rho_s4;
		side1_s5 <= side1_s4;
	end

	always_ff @(posedge clk) begin
		v_s6          <= {1'b0, ae2_s5} + {3'b0, az2_s5};
		side2_s6.rho  <= rho_s5;
		side2_s6.ae   <= ae_s5;
		side2_s6.eneg <= eneg_s5;
		side2_s6.enz  <= enz_s5;
		side2_s6.deg  <= (rho_s5 == '0) || (ae_s5 == '0 && side1_s5.az == '0);
		side2_s6.s1   <= side1_s5;
	end

	tdg_sqrt #(
		.RW (S_W),
		.SW ($bits(side2_t))
	) u_sqrt_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s6),
		.in_val   ({1'b0, v_s6}),
		.in_side  (side2_s6),
		.out_vld  (s_vld),
		.out_root (s_w),
		.out_side (side2_vec)
	);

	assign side2_w = side2_t'(side2_vec);
	assign dist_w  = {4'b0, minor_q} - {1'b0, s_w};

	always_ff @(posedge clk) begin
		den_s7            <= side2_w.rho * s_w;
		numx_s7           <= side2_w.s1.ax * side2_w.ae;
		numy_s7           <= side2_w.s1.ay * side2_w.ae;
		az_s7             <= side2_w.s1.az;
		s_s7              <= s_w;
		xside_s7.deg      <= side2_w.deg;
		xside_s7.gneg     <= (side2_w.s1.sgn.xneg == side2_w.eneg) && side2_w.enz
			&& side2_w.s1.sgn.xnz;
		gyneg_s7          <= (side2_w.s1.sgn.yneg == side2_w.eneg) && side2_w.enz
			&& side2_w.s1.sgn.ynz;
		gzneg_s7          <= side2_w.s1.sgn.zpos;
		xside_s7.dist_val <= (dist_w[34:31] != {4{dist_w[31]}}) ? 32'h8000_0000
			: dist_w[PT_W-1:0];
	end

	tdg_div #(
		.NW (DEN_W),
		.G  (G),
		.SW ($bits(xside_t))
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.num      (numx_s7),
		.den      (den_s7),
		.in_side  (xside_s7),
		.out_vld  (vld_x),
		.quot     (qx),
		.out_side (xside_vec)
	);

	tdg_div #(
		.NW (DEN_W),
		.G  (G),
		.SW (1)
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.num      (numy_s7),
		.den      (den_s7),
		.in_side  (gyneg_s7),
		.out_vld  (vld_y),
		.quot     (qy),
		.out_side (gyneg_w)
	);

	tdg_div #(
		.NW (DEN_W),
		.G  (G),
		.SW (1)
	) u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s7),
		.num      ({(DEN_W-MAG_W)'(0), az_s7}),
		.den      ({(DEN_W-S_W)'(0), s_s7}),
		.in_side  (gzneg_s7),
		.out_vld  (vld_z),
		.quot     (qz),
		.out_side (gzneg_w)
	);

	assign xside_w = xside_t'(xside_vec);

	always_ff @(posedge clk) begin
		distance   <= xside_w.dist_val;
		degenerate <= xside_w.deg;
		grad_x     <= gmap(qx, xside_w.gneg, xside_w.deg);
		grad_y     <= gmap(qy, gyneg_w, xside_w.deg);
		grad_z     <= gmap(qz, gzneg_w, xside_w.deg);
	end

`ifndef NO_ASSERTIONS
	a_div_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_x == vld_y) && (vld_x == vld_z))
		else $error("gradient divider lanes out of step");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> grad_x == '0 && grad_y == '0 && grad_z == '0)
		else $error("degenerate result with nonzero gradient");

	a_done_from_valid: assert property (@(posedge clk) disable iff (!arst_n)
		vld_x |=> done)
		else $error("divider result not delivered");
`endif

endmodule

### rtl/tdg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_sqrt
// Pipelined floor square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module tdg_sqrt
	import tdg_pkg::*;
#(
	parameter int RW = RHO_W,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [2*RW-1:0] in_val,
	input  logic [SW-1:0]   in_side,
	output logic            out_vld,
	output logic [RW-1:0]   out_root,
	output logic [SW-1:0]   out_side
);

	localparam int VW = 2 * RW;

	logic            vld_s  [RW];
	logic [VW-1:0]   val_s  [RW];
	logic [RW+1:0]   rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [SW-1:0]   side_s [RW];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic          vld_in;
		logic [VW-1:0] val_in;
		logic [RW+1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [SW-1:0] side_in;
		logic [RW+1:0] rem_sh;
		logic [RW+1:0] trial;
		logic          take;

		if (i == 0) begin : g_first
			assign vld_in  = in_vld;
			assign val_in  = in_val;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign val_in  = val_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign side_in = side_s[i-1];
		end

		assign rem_sh = {rem_in[RW-1:0], val_in[VW-1-2*i -: 2]};
		assign trial  = {root_in, 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			val_s[i]  <= val_in;
			rem_s[i]  <= take ? rem_sh - trial : rem_sh;
			root_s[i] <= {root_in[RW-2:0], take};
			side_s[i] <= side_in;
		end
	end

	assign out_vld  = vld_s[RW-1];
	assign out_root = root_s[RW-1];
	assign out_side = side_s[RW-1];

endmodule

### rtl/tdg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_div
// Pipelined unit quotient round(num * 2^G / den), clamped to 2^G, one
// quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
module tdg_div
	import tdg_pkg::*;
#(
	parameter int NW = DEN_W,
	parameter int G  = GRAD_FRAC_DEF,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [G:0]    quot,
	output logic [SW-1:0] out_side
);

	localparam logic [G+1:0] ONE = (G+2)'(1) << G;

	logic          vld_p;
	logic          clamp_p;
	logic [NW-1:0] num_p;
	logic [NW-1:0] den_p;
	logic [SW-1:0] side_p;

	logic          vld_s   [G+1];
	logic          clamp_s [G+1];
	logic [NW-1:0] r_s     [G+1];
	logic [G:0]    q_s     [G+1];
	logic [NW-1:0] den_s   [G+1];
	logic [SW-1:0] side_s  [G+1];

	logic          rnd;
	logic [G+1:0]  qf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
		end else begin
			vld_p <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		clamp_p <= {1'b0, num} >= {den, 1'b0};
		num_p   <= num;
		den_p   <= den;
		side_p  <= in_side;
	end

	for (genvar j = 0; j <= G; j++) begin : g_stage
		logic          vld_in;
		logic          clamp_in;
		logic [NW:0]   rr;
		logic [NW:0]   rn;
		logic [G:0]    q_in;
		logic [NW-1:0] den_in;
		logic [SW-1:0] side_in;
		logic          ge;

		if (j == 0) begin : g_first
			assign vld_in   = vld_p;
			assign clamp_in = clamp_p;
			assign rr       = {1'b0, num_p};
			assign q_in     = '0;
			assign den_in   = den_p;
			assign side_in  = side_p;
		end else begin : g_next
			assign vld_in   = vld_s[j-1];
			assign clamp_in = clamp_s[j-1];
			assign rr       = {r_s[j-1], 1'b0};
			assign q_in     = q_s[j-1];
			assign den_in   = den_s[j-1];
			assign side_in  = side_s[j-1];
		end

		assign ge = rr >= {1'b0, den_in};
		assign rn = ge ? rr - {1'b0, den_in} : rr;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			clamp_s[j] <= clamp_in;
			r_s[j]     <= rn[NW-1:0];
			q_s[j]     <= (G+1)'({q_in, ge});
			den_s[j]   <= den_in;
			side_s[j]  <= side_in;
		end
	end

	assign rnd = {r_s[G], 1'b0} >= {1'b0, den_s[G]};
	assign qf  = {1'b0, q_s[G]} + (G+2)'(rnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s[G];
		end
	end

	always_ff @(posedge clk) begin
		quot     <= (clamp_s[G] || qf > ONE) ? ONE[G:0] : qf[G:0];
		out_side <= side_s[G];
	end

endmodule

### dv/tdg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_checker
// Watches the point, config and result channels of the torus distance/gradient
// unit. Each point transfer is turned into a predicted distance, gradient and
// degenerate flag using the current register copy. Each result is compared
// with the oldest prediction in order.
// ----------------------------------------------------------------------------
module tdg_checker
	import tdg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic signed [PT_W-1:0]   point_x,
	input  logic signed [PT_W-1:0]   point_y,
	input  logic signed [PT_W-1:0]   point_z,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [PT_W-1:0]          cfg_data,
	input  logic                     done,
	input  logic signed [PT_W-1:0]   distance,
	input  logic signed [GRAD_W-1:0] grad_x,
	input  logic signed [GRAD_W-1:0] grad_y,
	input  logic signed [GRAD_W-1:0] grad_z,
	input  logic                     degenerate,
	output int                       fail_count,
	output int                       results_pending
);

	typedef logic [127:0] wide_t;

	typedef struct {
		logic [PT_W-1:0]   distance;
		logic [GRAD_W-1:0] gx;
		logic [GRAD_W-1:0] gy;
		logic [GRAD_W-1:0] gz;
		logic              deg;
	} torus_result_t;

	torus_result_t pending_results[$];
	longint cen_x, cen_y, cen_z, maj_r, min_r;

	assign results_pending = pending_results.size();

	function automatic wide_t floor_sqrt(wide_t v);
		wide_t r, c;
		r = '0;
		for (int b = 40; b >= 0; b--) begin
			c = r | (wide_t'(1) << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic wide_t unit_quotient(wide_t num, wide_t den);
		wide_t q, t, one;
		one = wide_t'(1) << GRAD_FRAC_DEF;
		num = num << GRAD_FRAC_DEF;
		if (num >= (den << (GRAD_FRAC_DEF + 1)))
			return one;
		q = '0;
		for (int b = GRAD_FRAC_DEF; b >= 0; b--) begin
			t = den << b;
			if (num >= t) begin
				num = num - t;
				q = q | (wide_t'(1) << b);
			end
		end
		if ((num << 1) >= den)
			q = q + 1;
		return (q > one) ? one : q;
	endfunction

	function automatic logic [GRAD_W-1:0] apply_sign(wide_t m, logic neg);
		logic [GRAD_W-1:0] v;
		v = m[GRAD_W-1:0];
		return neg ? -v : v;
	endfunction

	function automatic torus_result_t torus_predict(logic signed [PT_W-1:0] px,
			logic signed [PT_W-1:0] py, logic signed [PT_W-1:0] pz);
		torus_result_t res;
		longint dx, dy, dz, e, dist_sat;
		wide_t ax, ay, az, ae, rho, v, s, den;
		logic eneg;
		dx = longint'(px) - cen_x;
		dy = longint'(py) - cen_y;
		dz = longint'(pz) - cen_z;
		ax = (dx < 0) ? wide_t'(-dx) : wide_t'(dx);
		ay = (dy < 0) ? wide_t'(-dy) : wide_t'(dy);
		az = (dz < 0) ? wide_t'(-dz) : wide_t'(dz);
		rho = floor_sqrt(ax * ax + ay * ay);
		e = longint'(rho) - maj_r;
		eneg = e < 0;
		ae = eneg ? wide_t'(-e) : wide_t'(e);
		v = ae * ae + az * az;
		s = floor_sqrt(v);
		dist_sat = min_r - longint'(s);
		if (dist_sat < -64'sd2147483648)
			dist_sat = -64'sd2147483648;
		if (dist_sat > 64'sd2147483647)
			dist_sat = 64'sd2147483647;
		res.distance = dist_sat[PT_W-1:0];
		res.gx = '0;
		res.gy = '0;
		res.gz = '0;
		res.deg = 1'b0;
		if (rho == 0 || v == 0) begin
			res.deg = 1'b1;
		end else begin
			den = rho * s;
			res.gx = apply_sign(unit_quotient(ax * ae, den),
				((dx < 0) == eneg) && e != 0 && dx != 0);
			res.gy = apply_sign(unit_quotient(ay * ae, den),
				((dy < 0) == eneg) && e != 0 && dy != 0);
			res.gz = apply_sign(unit_quotient(az, s), dz > 0);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		torus_result_t exp_r;
		if (!arst_n) begin
			cen_x = 0;
			cen_y = 0;
			cen_z = 0;
			maj_r = 0;
			min_r = 0;
			fail_count <= 0;
			pending_results.delete();
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result with no point outstanding");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = pending_results.pop_front();
					if (distance !== exp_r.distance || grad_x !== exp_r.gx
							|| grad_y !== exp_r.gy || grad_z !== exp_r.gz
							|| degenerate !== exp_r.deg)
						fail_count <= fail_count + 1;
					if (distance !== exp_r.distance)
						$error("distance expected %0d got %0d",
							$signed(exp_r.distance), distance);
					if (grad_x !== exp_r.gx)
						$error("grad_x expected %0d got %0d", $signed(exp_r.gx), grad_x);
					if (grad_y !== exp_r.gy)
						$error("grad_y expected %0d got %0d", $signed(exp_r.gy), grad_y);
					if (grad_z !== exp_r.gz)
						$error("grad_z expected %0d got %0d", $signed(exp_r.gz), grad_z);
					if (degenerate !== exp_r.deg)
						$error("degenerate expected %0d got %0d", exp_r.deg, degenerate);
				end
			end
			if (start && !busy)
				pending_results.push_back(torus_predict(point_x, point_y, point_z));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CENTER_X:     cen_x = longint'($signed(cfg_data));
					REG_CENTER_Y:     cen_y = longint'($signed(cfg_data));
					REG_CENTER_Z:     cen_z = longint'($signed(cfg_data));
					REG_MAJOR_RADIUS: maj_r = longint'(cfg_data[RAD_W-1:0]);
					REG_MINOR_RADIUS: min_r = longint'(cfg_data[RAD_W-1:0]);
					default: ;
				endcase
			end
		end
	end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the torus distance/gradient unit. Drives register writes
// and query points with random gaps across several torus settings, a short
// directed set of axis, centre-circle and extreme points second, then random
// points mostly near the torus. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
	import tdg_pkg::*;

	localparam int LATENCY     = GRAD_FRAC_DEF + 78;
	localparam int CYCLE_LIMIT = 400000;
	localparam int UNIT        = 1 << 16;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [PT_W-1:0]   point_x, point_y, point_z;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [PT_W-1:0]          cfg_data;
	logic                     done;
	logic signed [PT_W-1:0]   distance;
	logic signed [GRAD_W-1:0] grad_x, grad_y, grad_z;
	logic                     degenerate;
	int                       fail_count;
	int                       results_pending;
	int                       cycle_count = 0;
	logic [PT_W-1:0]          cx, cy, cz, maj, mnr;
	bit                       allow_gaps;

	torus_distance_gradient_top dut (.*);

	tdg_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int idle_gap();
		int k;
		k = $urandom_range(0, 99);
		if (!allow_gaps || k < 60)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [PT_W-1:0] z);
		int gap;
		gap = idle_gap();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic load_torus(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [PT_W-1:0] z,
			logic [PT_W-1:0] r_major, logic [PT_W-1:0] r_minor);
		cx  = x;
		cy  = y;
		cz  = z;
		maj = r_major;
		mnr = r_minor;
		write_reg(REG_CENTER_X, x);
		write_reg(REG_CENTER_Y, y);
		write_reg(REG_CENTER_Z, z);
		write_reg(REG_MAJOR_RADIUS, r_major);
		write_reg(REG_MINOR_RADIUS, r_minor);
	endtask

	function automatic logic [PT_W-1:0] near_offset();
		int k;
		k = $urandom_range(0, 3);
		case (k)
			0: return $urandom_range(0, 2) - 1;
			1: return $urandom_range(0, 2 * UNIT) - UNIT;
			2: return $urandom_range(0, 64 * UNIT) - 32 * UNIT;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_points(int count);
		int k;
		logic [PT_W-1:0] x, y, z, ring;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 9);
			ring = (maj[RAD_W-1:0] > 32'd0 && $urandom_range(0, 1)) ?
				{1'b0, maj[RAD_W-1:0]} : 32'd0;
			if (k < 2) begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end else if (k < 4) begin
				x = cx + near_offset();
				y = cy + near_offset();
				z = cz + near_offset();
			end else if (k == 4) begin
				x = cx;
				y = cy;
				z = cz + near_offset();
			end else begin
				x = cx + ($urandom_range(0, 1) ? ring : -ring) + near_offset();
				y = cy + near_offset();
				z = cz + near_offset();
				if ($urandom_range(0, 1)) begin
					x = cx + near_offset();
					y = cy + ($urandom_range(0, 1) ? ring : -ring) + near_offset();
				end
			end
			send_point(x, y, z);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		point_x     = '0;
		point_y     = '0;
		point_z     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_CENTER_X;
		cfg_data    = '0;
		allow_gaps  = 1'b1;
		cx = '0;
		cy = '0;
		cz = '0;
		maj = '0;
		mnr = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		random_points(150);
		drain();

		load_torus('0, '0, '0, 10 * UNIT, 3 * UNIT);
		allow_gaps = 1'b0;
		send_point(0, 0, 0);
		send_point(0, 0, 5 * UNIT);
		send_point(10 * UNIT, 0, 0);
		send_point(0, -10 * UNIT, 0);
		send_point(-10 * UNIT, 0, 0);
		send_point(12 * UNIT, 0, 0);
		send_point(8 * UNIT, 0, 0);
		send_point(10 * UNIT, 0, 2 * UNIT);
		send_point(10 * UNIT, 0, -2 * UNIT);
		send_point(-7 * UNIT, -7 * UNIT, UNIT);
		send_point(6 * UNIT, 8 * UNIT, 0);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000, 32'h80000000);
		send_point(32'h7fffffff, 32'h80000000, 0);
		send_point(1, 0, 0);
		send_point(0, 1, 0);
		send_point(-1, -1, -1);
		send_point(3, 4, 7);
		allow_gaps = 1'b1;
		random_points(250);
		drain();

		load_torus(32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff, 32'hffffffff);
		write_reg(REG_MINOR_RADIUS + 3'd1, $urandom);
		write_reg(REG_MINOR_RADIUS + 3'd2, $urandom);
		write_reg(REG_MINOR_RADIUS + 3'd3, $urandom);
		random_points(250);
		drain();

		load_torus(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'd0);
		random_points(200);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			allow_gaps = (ph != 1);
			if (ph[0])
				load_torus($urandom, $urandom, $urandom, $urandom, $urandom);
			else
				load_torus($urandom_range(0, 1 << 24) - (1 << 23),
					$urandom_range(0, 1 << 24) - (1 << 23), $urandom_range(0, 1 << 20),
					$urandom_range(0, 1 << 22), $urandom_range(0, 1 << 20));
			random_points(190);
			drain();
		end

		if (fail_count == 0 && results_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
